// ===== hw/rtl/tps_pkg.sv =====
// Package for the timer prescaler selector: widths, reset values, register
// indexes, the calibration state machine codes and the calibration bundle.
// No dependencies.
package tps_pkg;

	localparam int PSC_REGS           = 5;
	localparam int NUM_PRESCALERS_DEF = 5;

	localparam int CLK_W    = 25;
	localparam int SPAN_W   = 17;
	localparam int CNT_W    = 3;
	localparam int PSC_W    = 11;
	localparam int DLY_W    = 32;
	localparam int IDX_W    = 3;
	localparam int DIV_W    = 32;
	localparam int TCLK_W   = 30;
	localparam int QA_W     = 31;
	localparam int SPANUS_W = QA_W + SPAN_W;
	localparam int TICK_W   = TCLK_W + PSC_W;
	localparam int ALL_W    = TICK_W + SPAN_W;
	localparam int NS_W     = 42;

	localparam int US_PER_S  = 1000000;
	localparam int NS_PER_S  = 1000000000;
	localparam int NS_PER_US = 1000;

	localparam logic [CLK_W-1:0]  CLK_RST   = CLK_W'(16000000);
	localparam logic [SPAN_W-1:0] SPAN_RST  = SPAN_W'(256);
	localparam logic [CNT_W-1:0]  COUNT_RST = CNT_W'(5);
	localparam logic [PSC_REGS-1:0][PSC_W-1:0] PSC_RST = {
		PSC_W'(1024), PSC_W'(256), PSC_W'(64), PSC_W'(8), PSC_W'(1)
	};

	typedef enum logic [2:0] {
		REG_CLK,
		REG_SPAN,
		REG_COUNT,
		REG_PSC_A,
		REG_PSC_B,
		REG_PSC_C,
		REG_PSC_D,
		REG_PSC_E
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_DIVA,
		S_DIVB,
		S_TICK,
		S_ALL
	} cal_state_t;

	typedef struct packed {
		logic [SPANUS_W-1:0]               span_us;
		logic [SPAN_W-1:0]                 span;
		logic [PSC_W-1:0]                  slowest;
		logic [IDX_W-1:0]                  n_used;
		logic [PSC_REGS-1:0][PSC_W-1:0]    psc;
		logic [PSC_REGS-1:0][TICK_W-1:0]   tick;
		logic [PSC_REGS-1:0][ALL_W-1:0]    all_ns;
	} tps_cal_t;

endpackage

// ===== hw/rtl/timer_prescaler_selector.sv =====
// Top level of the timer prescaler selector: request handshake, configuration
// port, calibration and the request pipeline. Depends on tps_pkg, tps_setup, tps_pipe.
//
// Channel   Signals                                   Handshake
// request   start, busy, delay_us                     taken when start && !busy
// result    done, status, full_cycles,                one-cycle strobe on done
//           span_prescaler, chosen_prescaler,
//           start_count
// config    cfg_we, cfg_index, cfg_wdata              written when cfg_we
//
// A request can enter every cycle that busy is low; its result passes through
// 32 span-divider stages, 42 tick-divider stages, plus input, selection and
// output registers. After reset and after every configuration write the
// calibration sequencer runs (a load step, two 32-step serial divisions
// and two multiply steps for each prescaler entry) with busy high.
// Results cannot be held off by the receiver, so the pipeline never stalls.
module timer_prescaler_selector import tps_pkg::*; #(
	parameter int NUM_PRESCALERS = NUM_PRESCALERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [DLY_W-1:0]  delay_us,
	output logic              done,
	output logic              status,
	output logic [DLY_W-1:0]  full_cycles,
	output logic [PSC_W-1:0]  span_prescaler,
	output logic [PSC_W-1:0]  chosen_prescaler,
	output logic [SPAN_W-1:0] start_count,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [CLK_W-1:0]  cfg_wdata
);

	localparam int LATENCY = DLY_W + NS_W + 3;

	tps_cal_t cal;
	logic     accept;

	// A request is only taken once calibration has settled.
	assign accept = start && !busy;

	tps_setup #(
		.NUM_PRESCALERS(NUM_PRESCALERS)
	) u_setup (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.busy      (busy),
		.cal       (cal)
	);

	tps_pipe u_pipe (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (accept),
		.delay_us         (delay_us),
		.cal              (cal),
		.out_valid        (done),
		.status           (status),
		.full_cycles      (full_cycles),
		.span_prescaler   (span_prescaler),
		.chosen_prescaler (chosen_prescaler),
		.start_count      (start_count)
	);

`ifndef ASSERT_OFF
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done)
		else $error("result strobe missing after a request");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, LATENCY))
		else $error("result strobe without a request");

	a_fail_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (chosen_prescaler == '0) && (start_count == '0))
		else $error("failed result carries a prescaler or start value");
`endif

endmodule

// ===== hw/rtl/tps_setup.sv =====
// Configuration registers and the calibration sequencer that derives span time,
// tick times and full-span times from them with a serial divider.
// Depends on tps_pkg.
module tps_setup import tps_pkg::*; #(
	parameter int NUM_PRESCALERS = NUM_PRESCALERS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [CLK_W-1:0] cfg_wdata,
	output logic             busy,
	output tps_cal_t         cal
);

	localparam int NE = (NUM_PRESCALERS < PSC_REGS) ? NUM_PRESCALERS : PSC_REGS;

	logic [CLK_W-1:0]               clk_hz_q;
	logic [SPAN_W-1:0]              span_q;
	logic [CNT_W-1:0]               count_q;
	logic [PSC_REGS-1:0][PSC_W-1:0] psc_q;

	cal_state_t          state_q, state_nx;
	logic [4:0]          cnt_q;
	logic [IDX_W-1:0]    idx_q;
	logic [DIV_W-1:0]    dvd_q;
	logic [CLK_W-1:0]    rem_q;
	logic [QA_W-1:0]     qa_q;
	logic [TCLK_W-1:0]   tclk_q;
	logic [SPANUS_W-1:0] span_us_q;
	logic [PSC_REGS-1:0][TICK_W-1:0] tick_q;
	logic [PSC_REGS-1:0][ALL_W-1:0]  all_q;

	logic [IDX_W-1:0] pidx;
	logic [IDX_W-1:0] n_used;
	logic [PSC_W-1:0] slowest;
	logic [CLK_W-1:0] clk1;
	logic [CLK_W:0]   rem_sh;
	logic [CLK_W:0]   rem_sub;
	logic             ge;
	logic [DIV_W-1:0] quot;

	assign pidx = IDX_W'(cfg_index - REG_PSC_A);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= CLK_RST;
			span_q   <= SPAN_RST;
			count_q  <= COUNT_RST;
			psc_q    <= PSC_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_CLK:   clk_hz_q <= cfg_wdata;
				REG_SPAN:  span_q   <= cfg_wdata[SPAN_W-1:0];
				REG_COUNT: count_q  <= cfg_wdata[CNT_W-1:0];
				REG_PSC_A, REG_PSC_B, REG_PSC_C, REG_PSC_D, REG_PSC_E: begin
					psc_q[pidx] <= cfg_wdata[PSC_W-1:0];
				end
				default: ;
			endcase
		end
	end

	// A zero count means one entry; anything above the usable entries is clipped.
	always_comb begin
		if (count_q == '0) begin
			n_used = IDX_W'(1);
		end else if (count_q > CNT_W'(NE)) begin
			n_used = IDX_W'(NE);
		end else begin
			n_used = count_q;
		end
	end

	assign slowest = psc_q[IDX_W'(n_used - 1'b1)];
	assign clk1    = (clk_hz_q == '0) ? CLK_W'(1) : clk_hz_q;

	assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
	assign ge      = (rem_sh >= {1'b0, clk1});
	assign rem_sub = ge ? (rem_sh - {1'b0, clk1}) : rem_sh;
	assign quot    = {dvd_q[DIV_W-2:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE: state_nx = S_IDLE;
			S_LOAD: state_nx = S_DIVA;
			S_DIVA: if (cnt_q == 5'd31) state_nx = S_DIVB;
			S_DIVB: if (cnt_q == 5'd31) state_nx = S_TICK;
			S_TICK: state_nx = S_ALL;
			S_ALL:  if (idx_q == IDX_W'(PSC_REGS - 1)) state_nx = S_IDLE;
				else state_nx = S_TICK;
			default: state_nx = S_LOAD;
		endcase
		if (cfg_we) state_nx = S_LOAD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			case (state_q)
				S_LOAD:         cnt_q <= '0;
				S_DIVA:         cnt_q <= cnt_q + 5'd1;
				S_DIVB: begin
					cnt_q <= cnt_q + 5'd1;
					idx_q <= '0;
				end
				S_ALL:          idx_q <= idx_q + 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_LOAD: begin
				dvd_q <= DIV_W'(US_PER_S * slowest);
				rem_q <= '0;
			end
			S_DIVA: begin
				if (cnt_q == 5'd31) begin
					qa_q  <= quot[QA_W-1:0];
					dvd_q <= DIV_W'(NS_PER_S);
					rem_q <= '0;
				end else begin
					dvd_q <= quot;
					rem_q <= rem_sub[CLK_W-1:0];
				end
			end
			S_DIVB: begin
				dvd_q <= quot;
				rem_q <= rem_sub[CLK_W-1:0];
				if (cnt_q == 5'd31) tclk_q <= quot[TCLK_W-1:0];
			end
			S_TICK: begin
				tick_q[idx_q] <= TICK_W'(tclk_q) * TICK_W'(psc_q[idx_q]);
				span_us_q     <= SPANUS_W'(qa_q) * SPANUS_W'(span_q);
			end
			S_ALL: begin
				all_q[idx_q] <= ALL_W'(tick_q[idx_q]) * ALL_W'(span_q);
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);

	assign cal.span_us = span_us_q;
	assign cal.span    = span_q;
	assign cal.slowest = slowest;
	assign cal.n_used  = n_used;
	assign cal.psc     = psc_q;
	assign cal.tick    = tick_q;
	assign cal.all_ns  = all_q;

endmodule

// ===== hw/rtl/tps_pipe.sv =====
// Request pipeline: span divider, prescaler selection, tick divider and the
// output register. Depends on tps_pkg and the calibration bundle from tps_setup.
module tps_pipe import tps_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic [DLY_W-1:0]  delay_us,
	input  tps_cal_t          cal,
	output logic              out_valid,
	output logic              status,
	output logic [DLY_W-1:0]  full_cycles,
	output logic [PSC_W-1:0]  span_prescaler,
	output logic [PSC_W-1:0]  chosen_prescaler,
	output logic [SPAN_W-1:0] start_count
);

	localparam int D1 = DLY_W;
	localparam int D2 = NS_W;

	// Span divider stages; entry 0 is the input register.
	logic                d1_v_s [0:D1];
	logic [DLY_W-1:0]    d1_q_s [0:D1];
	logic [SPANUS_W-1:0] d1_r_s [0:D1];

	// Tick divider stages; entry 0 is the selection register.
	logic                d2_v_s [0:D2];
	logic [NS_W-1:0]     d2_q_s [0:D2];
	logic [TICK_W-1:0]   d2_r_s [0:D2];
	logic [TICK_W-1:0]   d2_t_s [0:D2];
	logic                d2_f_s [0:D2];
	logic [PSC_W-1:0]    d2_p_s [0:D2];
	logic [DLY_W-1:0]    d2_c_s [0:D2];
	logic [PSC_W-1:0]    d2_sp_s [0:D2];

	logic [NS_W-1:0]   rest_ns;
	logic              hit;
	logic [IDX_W-1:0]  sel;

	logic              out_valid_q;
	logic              status_q;
	logic [DLY_W-1:0]  cycles_q;
	logic [PSC_W-1:0]  span_psc_q;
	logic [PSC_W-1:0]  chosen_q;
	logic [SPAN_W-1:0] start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d1_v_s[0] <= 1'b0;
		else         d1_v_s[0] <= in_valid;
	end

	always_ff @(posedge clk) begin
		d1_q_s[0] <= delay_us;
		d1_r_s[0] <= '0;
	end

	for (genvar k = 0; k < D1; k++) begin : g_d1
		logic [SPANUS_W:0] sh;
		logic [SPANUS_W:0] sub;
		logic              ge;
		// A zero span time never subtracts, so the whole delay falls through.
		assign sh  = {d1_r_s[k], d1_q_s[k][DLY_W-1]};
		assign ge  = (cal.span_us != '0) && (sh >= {1'b0, cal.span_us});
		assign sub = ge ? (sh - {1'b0, cal.span_us}) : sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d1_v_s[k+1] <= 1'b0;
			else         d1_v_s[k+1] <= d1_v_s[k];
		end
		always_ff @(posedge clk) begin
			d1_q_s[k+1] <= {d1_q_s[k][DLY_W-2:0], ge};
			d1_r_s[k+1] <= sub[SPANUS_W-1:0];
		end
	end

	assign rest_ns = NS_W'(d1_r_s[D1][DLY_W-1:0]) * NS_W'(NS_PER_US);

	always_comb begin
		hit = 1'b0;
		sel = '0;
		for (int i = PSC_REGS - 1; i >= 0; i--) begin
			if ((i < int'(cal.n_used)) && (ALL_W'(rest_ns) <= cal.all_ns[i])) begin
				hit = 1'b1;
				sel = IDX_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) d2_v_s[0] <= 1'b0;
		else         d2_v_s[0] <= d1_v_s[D1];
	end

	always_ff @(posedge clk) begin
		d2_q_s[0]  <= rest_ns;
		d2_r_s[0]  <= '0;
		d2_t_s[0]  <= cal.tick[sel];
		d2_f_s[0]  <= hit;
		d2_p_s[0]  <= cal.psc[sel];
		d2_c_s[0]  <= d1_q_s[D1];
		d2_sp_s[0] <= (d1_q_s[D1] != '0) ? cal.slowest : '0;
	end

	for (genvar k = 0; k < D2; k++) begin : g_d2
		logic [TICK_W:0] sh;
		logic [TICK_W:0] sub;
		logic            ge;
		// A zero tick time only matches a zero rest, whose tick count is zero.
		assign sh  = {d2_r_s[k], d2_q_s[k][NS_W-1]};
		assign ge  = (d2_t_s[k] != '0) && (sh >= {1'b0, d2_t_s[k]});
		assign sub = ge ? (sh - {1'b0, d2_t_s[k]}) : sh;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) d2_v_s[k+1] <= 1'b0;
			else         d2_v_s[k+1] <= d2_v_s[k];
		end
		always_ff @(posedge clk) begin
			d2_q_s[k+1]  <= {d2_q_s[k][NS_W-2:0], ge};
			d2_r_s[k+1]  <= sub[TICK_W-1:0];
			d2_t_s[k+1]  <= d2_t_s[k];
			d2_f_s[k+1]  <= d2_f_s[k];
			d2_p_s[k+1]  <= d2_p_s[k];
			d2_c_s[k+1]  <= d2_c_s[k];
			d2_sp_s[k+1] <= d2_sp_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else         out_valid_q <= d2_v_s[D2];
	end

	always_ff @(posedge clk) begin
		status_q   <= !d2_f_s[D2];
		cycles_q   <= d2_c_s[D2];
		span_psc_q <= d2_sp_s[D2];
		chosen_q   <= d2_f_s[D2] ? d2_p_s[D2] : '0;
		start_q    <= d2_f_s[D2] ? (cal.span - d2_q_s[D2][SPAN_W-1:0]) : '0;
	end

	assign out_valid        = out_valid_q;
	assign status           = status_q;
	assign full_cycles      = cycles_q;
	assign span_prescaler   = span_psc_q;
	assign chosen_prescaler = chosen_q;
	assign start_count      = start_q;

endmodule
